FILE: rtl/mmrq_pkg.sv
`default_nettype none

package mmrq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 1024;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // stored entry: full mark, status, first data, second data
  localparam int ENTRY_W = 25;

  // request commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // status byte classes
  localparam logic [7:0] ST_TIMING_CLOCK = 8'hF8;
  localparam logic [7:0] ST_START        = 8'hFA;
  localparam logic [7:0] ST_CONTINUE     = 8'hFB;
  localparam logic [7:0] ST_STOP         = 8'hFC;
  localparam logic [7:0] ST_RESET        = 8'hFF;
  localparam logic [3:0] SYSTEM_NIBBLE   = 4'hF;

  // data bytes that follow a status byte, by high nibble 8..F
  localparam logic [1:0] DATA_BYTES [8] = '{2'd2, 2'd2, 2'd2, 2'd2,
                                            2'd1, 2'd1, 2'd2, 2'd0};

  typedef struct packed {
    logic       command;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [5:0] byte_budget;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [5:0] byte_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic sweep;        // clearing pass write at write pointer
    logic push;         // store request message at write pointer
    logic start_drain;  // latch budget, zero byte count
    logic read;         // read entry at read pointer
    logic take;         // charge budget for the current message
    logic emit_byte;    // load next message byte into output register
    logic emit_final;   // load final count item into output register
    logic retire;       // clear entry at read pointer and advance
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic ent_full;
    logic ent_kept;
    logic ent_fits;
    logic byte_last;
    logic out_free;
  } stat_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [1:0] data_bytes(input logic [7:0] st);
    return DATA_BYTES[st[6:4]];
  endfunction

  function automatic logic status_kept(input logic [7:0] st);
    logic k;
    if (!st[7]) begin
      k = 1'b0;
    end else if (st[7:4] == SYSTEM_NIBBLE) begin
      k = (st == ST_TIMING_CLOCK) || (st == ST_START) || (st == ST_CONTINUE) ||
          (st == ST_STOP) || (st == ST_RESET);
    end else begin
      k = 1'b1;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/midi_message_ring_queue.sv
`default_nettype none

// Ring queue of MIDI messages. A push request stores status and two data bytes
// at the write pointer, overwriting whatever is there; a drain request walks
// full entries from the read pointer, drops non-status and unsupported system
// messages, and returns the kept messages as 1 to 3 byte transfers within the
// byte budget, then one final transfer with the count. Messages live in one
// single-port-write memory of QUEUE_DEPTH entries with a registered read, so a
// drain reads each entry it looks at and then evaluates it, emits each byte
// through the output register, which the consumer can stall, and ends with the
// final transfer. After reset the block runs a clearing pass over all
// QUEUE_DEPTH entries before taking requests.
module midi_message_ring_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mmrq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mmrq_pkg::rsp_t rsp
);

  mmrq_pkg::ctrl_t cmd;
  mmrq_pkg::stat_t sts;

  mmrq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_ready   (req_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  mmrq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/mmrq_datapath.sv
`default_nettype none

module mmrq_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mmrq_pkg::req_t  req,
  input  mmrq_pkg::ctrl_t cmd,
  output mmrq_pkg::stat_t sts,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mmrq_pkg::rsp_t  rsp
);

  logic [mmrq_pkg::ENTRY_W-1:0] mem [mmrq_pkg::QUEUE_DEPTH];
  logic [mmrq_pkg::ENTRY_W-1:0] entry;
  logic [mmrq_pkg::PTR_W-1:0]   wp;
  logic [mmrq_pkg::PTR_W-1:0]   rp;
  logic [5:0]                   budget;
  logic [5:0]                   count;
  logic [1:0]                   idx;

  logic                         mem_we;
  logic [mmrq_pkg::PTR_W-1:0]   mem_waddr;
  logic [mmrq_pkg::ENTRY_W-1:0] mem_wdata;
  logic [7:0]                   ent_st;
  logic [7:0]                   ent_d1;
  logic [7:0]                   ent_d2;
  logic [1:0]                   nd;
  logic [2:0]                   need;
  logic [7:0]                   byte_sel;

  // write port select: push, clearing pass or retire
  always_comb begin
    mem_we = cmd.push | cmd.sweep | cmd.retire;
    if (cmd.push) begin
      mem_waddr = wp;
      mem_wdata = {1'b1, req.status_byte, req.first_data, req.second_data};
    end else if (cmd.sweep) begin
      mem_waddr = wp;
      mem_wdata = '0;
    end else begin
      mem_waddr = rp;
      mem_wdata = '0;
    end
  end

  // queue memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      entry <= mem[rp];
    end
  end

  // entry decode
  always_comb begin
    ent_st = entry[23:16];
    ent_d1 = entry[15:8];
    ent_d2 = entry[7:0];
    nd     = mmrq_pkg::data_bytes(ent_st);
    need   = {1'b0, nd} + 3'd1;
    case (idx)
      2'd0:    byte_sel = ent_st;
      2'd1:    byte_sel = ent_d1;
      default: byte_sel = ent_d2;
    endcase
  end

  // status to controller
  always_comb begin
    sts.sweep_last = (wp == mmrq_pkg::PTR_W'(mmrq_pkg::QUEUE_DEPTH - 1));
    sts.ent_full   = entry[24];
    sts.ent_kept   = mmrq_pkg::status_kept(ent_st);
    sts.ent_fits   = ({3'b000, need} <= budget);
    sts.byte_last  = (idx == nd);
    sts.out_free   = !rsp_valid || rsp_ready;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (cmd.push || cmd.sweep) begin
        wp <= mmrq_pkg::next_ptr(wp);
      end
      if (cmd.retire) begin
        rp <= mmrq_pkg::next_ptr(rp);
      end
    end
  end

  // budget, byte count and byte index
  always_ff @(posedge clk) begin
    if (cmd.start_drain) begin
      budget <= req.byte_budget;
      count  <= '0;
    end else if (cmd.take) begin
      budget <= budget - {3'b000, need};
      count  <= count + {3'b000, need};
    end
    if (cmd.take) begin
      idx <= '0;
    end else if (cmd.emit_byte) begin
      idx <= idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_final) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      rsp.out_byte   <= byte_sel;
      rsp.byte_valid <= 1'b1;
      rsp.last       <= 1'b0;
      rsp.byte_count <= '0;
    end else if (cmd.emit_final) begin
      rsp.out_byte   <= '0;
      rsp.byte_valid <= 1'b0;
      rsp.last       <= 1'b1;
      rsp.byte_count <= count;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mmrq_ctrl.sv
`default_nettype none

module mmrq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_command,
  output logic           req_ready,
  input  mmrq_pkg::stat_t sts,
  output mmrq_pkg::ctrl_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of push, drain walk and emission
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_command == mmrq_pkg::CMD_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            cmd.start_drain = 1'b1;
            state_next      = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.ent_full) begin
          state_next = S_FINAL;
        end else if (!sts.ent_kept) begin
          cmd.retire = 1'b1;
          state_next = S_READ;
        end else if (!sts.ent_fits) begin
          state_next = S_FINAL;
        end else begin
          cmd.take   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.byte_last) begin
            cmd.retire = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mmrq_checker.sv
`default_nettype none

module mmrq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input mmrq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input mmrq_pkg::rsp_t rsp
);

  // a stalled request transfer holds its payload
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // a stalled result transfer holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // byte items never carry last, the final item always does
  a_final_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.byte_valid != rsp.last))
    else $error("byte_valid and last both set or both clear");

  // byte items carry a zero count
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.byte_valid |-> (rsp.byte_count == 6'd0))
    else $error("byte item with nonzero count");

  // no request is taken right after reset while the clearing pass runs
  a_clear_pass: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request ready during clearing pass");

endmodule

bind midi_message_ring_queue mmrq_checker u_mmrq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

FILE: tb/tb_midi_message_ring_queue.sv
`timescale 1ns / 100ps

module tb_midi_message_ring_queue;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_SETTLE = 64;
  localparam int IDLE_PERCENT = 37;

  // status classes that carry a single data byte
  localparam logic [3:0] PROGRAM_CHANGE   = 4'hC;
  localparam logic [3:0] CHANNEL_PRESSURE = 4'hD;

  // real-time system messages that survive a drain
  localparam logic [7:0] KEPT_SYSTEM [5] = '{mmrq_pkg::ST_TIMING_CLOCK, mmrq_pkg::ST_START,
                                             mmrq_pkg::ST_CONTINUE, mmrq_pkg::ST_STOP,
                                             mmrq_pkg::ST_RESET};

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  mmrq_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  mmrq_pkg::rsp_t rsp;

  // shadow copy of the queue
  logic [23:0]                msg_mem [mmrq_pkg::QUEUE_DEPTH];
  bit                         full_mark [mmrq_pkg::QUEUE_DEPTH];
  logic [mmrq_pkg::PTR_W-1:0] wr_ptr = '0;
  logic [mmrq_pkg::PTR_W-1:0] rd_ptr = '0;
  int                         marked_entries = 0;

  mmrq_pkg::rsp_t expected_midi_out [$];
  int   mismatches  = 0;
  int   cycle_count = 0;
  bit   steady      = 1'b0;

  midi_message_ring_queue dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // consumer stalls
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_midi_out
    mmrq_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_midi_out.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, rsp);
        mismatches++;
      end else begin
        want = expected_midi_out.pop_front();
        if (rsp.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, rsp.out_byte);
          mismatches++;
        end
        if (rsp.byte_valid !== want.byte_valid) begin
          $display("%0t: byte_valid expected %b actual %b", $time, want.byte_valid,
                   rsp.byte_valid);
          mismatches++;
        end
        if (rsp.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, rsp.last);
          mismatches++;
        end
        if (rsp.byte_count !== want.byte_count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                   rsp.byte_count);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [mmrq_pkg::PTR_W-1:0] ptr_after(
    input logic [mmrq_pkg::PTR_W-1:0] p);
    return mmrq_pkg::PTR_W'((int'(p) + 1) % mmrq_pkg::QUEUE_DEPTH);
  endfunction

  function automatic bit midi_status_kept(input logic [7:0] st);
    bit keep;
    keep = 1'b0;
    if (st[7] && st[7:4] != mmrq_pkg::SYSTEM_NIBBLE) begin
      keep = 1'b1;
    end else if (st[7]) begin
      foreach (KEPT_SYSTEM[i]) begin
        if (st == KEPT_SYSTEM[i]) keep = 1'b1;
      end
    end
    return keep;
  endfunction

  function automatic int midi_data_len(input logic [7:0] st);
    int n;
    case (st[7:4])
      PROGRAM_CHANGE, CHANNEL_PRESSURE: n = 1;
      mmrq_pkg::SYSTEM_NIBBLE:          n = 0;
      default:                          n = 2;
    endcase
    return n;
  endfunction

  // update the shadow queue and queue up the bytes a drain returns
  function automatic void predict_midi_out(input mmrq_pkg::req_t r);
    int             room;
    int             total;
    int             visits;
    int             n_data;
    logic [7:0]     st;
    mmrq_pkg::rsp_t item;
    if (r.command == mmrq_pkg::CMD_PUSH) begin
      msg_mem[wr_ptr] = {r.status_byte, r.first_data, r.second_data};
      if (!full_mark[wr_ptr]) marked_entries++;
      full_mark[wr_ptr] = 1'b1;
      wr_ptr = ptr_after(wr_ptr);
    end else begin
      room   = r.byte_budget;
      total  = 0;
      visits = 0;
      while (visits < mmrq_pkg::QUEUE_DEPTH && full_mark[rd_ptr]) begin
        st = msg_mem[rd_ptr][23:16];
        if (midi_status_kept(st)) begin
          n_data = midi_data_len(st);
          // message does not fit: it stays queued for the next drain
          if (n_data + 1 > room) break;
          room  -= n_data + 1;
          total += n_data + 1;
          item = '0;
          item.byte_valid = 1'b1;
          item.out_byte = st;
          expected_midi_out.push_back(item);
          if (n_data >= 1) begin
            item.out_byte = msg_mem[rd_ptr][15:8];
            expected_midi_out.push_back(item);
          end
          if (n_data >= 2) begin
            item.out_byte = msg_mem[rd_ptr][7:0];
            expected_midi_out.push_back(item);
          end
        end
        full_mark[rd_ptr] = 1'b0;
        marked_entries--;
        rd_ptr = ptr_after(rd_ptr);
        visits++;
      end
      item = '0;
      item.last = 1'b1;
      item.byte_count = 6'(total);
      expected_midi_out.push_back(item);
    end
  endfunction

  // present one request and hold it until the transfer
  task automatic send_request(input mmrq_pkg::req_t item);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    predict_midi_out(item);
  endtask

  task automatic push_msg(input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2);
    mmrq_pkg::req_t item;
    item.command     = mmrq_pkg::CMD_PUSH;
    item.status_byte = st;
    item.first_data  = d1;
    item.second_data = d2;
    item.byte_budget = 6'($urandom);
    send_request(item);
  endtask

  task automatic drain_queue(input logic [5:0] budget);
    mmrq_pkg::req_t item;
    item.command     = mmrq_pkg::CMD_DRAIN;
    item.status_byte = 8'($urandom);
    item.first_data  = 8'($urandom);
    item.second_data = 8'($urandom);
    item.byte_budget = budget;
    send_request(item);
  endtask

  // channel message with two data bytes
  function automatic logic [7:0] three_byte_status();
    logic [7:0] st;
    do st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
    while (st[7:4] == PROGRAM_CHANGE || st[7:4] == CHANNEL_PRESSURE);
    return st;
  endfunction

  // status byte that a drain passes over
  function automatic logic [7:0] dropped_status();
    logic [7:0] st;
    if ($urandom_range(0, 1) == 0) begin
      st = 8'($urandom_range(0, 127));
    end else begin
      do st = {mmrq_pkg::SYSTEM_NIBBLE, 4'($urandom)};
      while (midi_status_kept(st));
    end
    return st;
  endfunction

  // mostly kept messages, some arbitrary bytes
  function automatic logic [7:0] random_status();
    logic [7:0] st;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      6, 7:             st = KEPT_SYSTEM[$urandom_range(0, 4)];
      default:          st = 8'($urandom);
    endcase
    return st;
  endfunction

  function automatic logic [5:0] random_budget();
    int pick;
    logic [5:0] b;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      b = 6'd63;
    end else if (pick < 5) begin
      b = 6'($urandom_range(0, 5));
    end else begin
      b = 6'($urandom);
    end
    return b;
  endfunction

  // drains of an empty queue
  task automatic test_empty_drain();
    drain_queue(6'd0);
    drain_queue(6'd63);
  endtask

  // every status class, kept and dropped, with data extremes
  task automatic test_status_classes();
    push_msg(8'h00, 8'hFF, 8'hFF);
    push_msg(8'h80, 8'h00, 8'hFF);
    push_msg(8'h9F, 8'hFF, 8'h00);
    push_msg(8'h7F, 8'h12, 8'h34);
    push_msg(8'hA5, 8'h7F, 8'h80);
    push_msg(8'hB0, 8'h01, 8'hFE);
    push_msg(8'hF0, 8'h00, 8'h00);
    push_msg(8'hC3, 8'h55, 8'hAA);
    push_msg(8'hDF, 8'hAA, 8'h55);
    push_msg(8'hE0, 8'hFF, 8'hFF);
    push_msg(mmrq_pkg::ST_TIMING_CLOCK, 8'h11, 8'h22);
    push_msg(8'hF7, 8'h00, 8'h00);
    push_msg(mmrq_pkg::ST_START, 8'hFF, 8'hFF);
    push_msg(8'hF9, 8'h33, 8'h44);
    push_msg(mmrq_pkg::ST_CONTINUE, 8'h00, 8'h00);
    push_msg(8'hFD, 8'h00, 8'h00);
    push_msg(mmrq_pkg::ST_STOP, 8'h5A, 8'hA5);
    push_msg(8'hFE, 8'hFF, 8'hFF);
    push_msg(mmrq_pkg::ST_RESET, 8'hFF, 8'h00);
    drain_queue(6'd63);
  endtask

  // messages that do not fit, exact fits and a full budget
  task automatic test_budget_limits();
    push_msg(8'h90, 8'h3C, 8'h64);
    push_msg(8'hC0, 8'h05, 8'h00);
    drain_queue(6'd2);
    drain_queue(6'd3);
    drain_queue(6'd1);
    drain_queue(6'd2);
    push_msg(mmrq_pkg::ST_STOP, 8'h00, 8'h00);
    drain_queue(6'd1);
    repeat (22) push_msg(three_byte_status(), 8'($urandom), 8'($urandom));
    drain_queue(6'd63);
    drain_queue(6'd63);
  endtask

  // long run of dropped entries behind a few kept ones
  task automatic test_dropped_run();
    repeat (6) push_msg(three_byte_status(), 8'($urandom), 8'($urandom));
    repeat (40) push_msg(dropped_status(), 8'($urandom), 8'($urandom));
    drain_queue(random_budget());
    while (marked_entries != 0) drain_queue(6'd63);
    repeat (3) push_msg(random_status(), 8'($urandom), 8'($urandom));
    drain_queue(6'd63);
  endtask

  task automatic test_random_traffic(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        drain_queue(random_budget());
      end else begin
        push_msg(random_status(), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // random traffic with both sides always willing
  task automatic test_steady_traffic(input int n_items);
    steady <= 1'b1;
    test_random_traffic(n_items);
    steady <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_drain();
    test_status_classes();
    test_budget_limits();
    test_dropped_run();
    test_random_traffic(220);
    test_steady_traffic(140);
    req_valid <= 1'b0;
    while (expected_midi_out.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
